// File: hdl/sgped_pkg.sv
// sgped_pkg: widths, register indexes and shared types for the scanline
// gradient peak edge detector. No dependencies.
`default_nettype none

package sgped_pkg;

   localparam int LUMA_BITS  = 8;
   localparam int GRAD_BITS  = 10;
   localparam int COUNT_BITS = 6;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type CSR_EDGE_THRESHOLD = 2'd0;
   localparam csr_idx_type CSR_MAX_EDGES      = 2'd1;

   typedef logic        [LUMA_BITS-1:0]  luma_type;
   typedef logic signed [GRAD_BITS-1:0]  grad_type;
   typedef logic        [COUNT_BITS-1:0] count_type;

endpackage

`default_nettype wire

// File: hdl/sgped_if.sv
// sgped_if: valid/ready channel interfaces for samples, edges and register writes.
// Depends on sgped_pkg.
`default_nettype none

interface sgped_req_if #(
   parameter int COORD_BITS = 10
);
   logic                           valid;
   logic                           ready;
   sgped_pkg::luma_type            luma;
   logic                           is_field_green;
   logic [COORD_BITS-1:0]          pos_x;
   logic [COORD_BITS-1:0]          pos_y;
   logic                           line_start;

   modport source (output valid, luma, is_field_green, pos_x, pos_y, line_start,
                   input ready);
   modport sink   (input valid, luma, is_field_green, pos_x, pos_y, line_start,
                   output ready);
endinterface

interface sgped_rsp_if #(
   parameter int COORD_BITS = 10
);
   logic                           valid;
   logic                           ready;
   logic [COORD_BITS-1:0]          edge_x;
   logic [COORD_BITS-1:0]          edge_y;
   sgped_pkg::grad_type            edge_strength;
   logic                           budget_full;

   modport source (output valid, edge_x, edge_y, edge_strength, budget_full,
                   input ready);
   modport sink   (input valid, edge_x, edge_y, edge_strength, budget_full,
                   output ready);
endinterface

interface sgped_csr_if;
   logic                                    valid;
   logic                                    ready;
   sgped_pkg::csr_idx_type                  index;
   logic [sgped_pkg::CSR_DATA_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/scanline_gradient_peak_edge_detector.sv
// Top level of the scanline gradient peak edge detector.
// Depends on sgped_pkg and the channel interfaces in sgped_if.
//
// Samples enter one per clock: a beat on req_bus is taken into an input
// register, the gradient, hysteresis and budget logic run on that register
// and any edge lands in the result register. The per-line state (last luma,
// extremes, peak position, edge count) is updated as the sample leaves the
// input register, which lets a new sample follow every cycle; only a stalled
// rsp_bus holding an edge holds the pipeline. Samples before the first
// line_start are dropped, and once max_edges edges are out the line is idle
// until the next line_start. Register writes on csr_bus are always taken and
// apply from the next sample.
`default_nettype none

module scanline_gradient_peak_edge_detector #(
   parameter int COORD_BITS = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   sgped_req_if.sink   req_bus,
   sgped_rsp_if.source rsp_bus,
   sgped_csr_if.sink   csr_bus
);
   import sgped_pkg::*;

   typedef logic [COORD_BITS-1:0] coord_type;

   // configuration
   luma_type  threshold_ff, threshold_in;
   count_type max_edges_ff, max_edges_in;

   // input register
   logic      s1_valid_ff, s1_valid_in;
   luma_type  s1_luma_ff;
   logic      s1_green_ff;
   coord_type s1_x_ff, s1_y_ff;
   logic      s1_start_ff;

   // line state
   logic      stopped_ff, stopped_in;
   luma_type  last_luma_ff, last_luma_in;
   logic      was_green_ff, was_green_in;
   grad_type  grad_max_ff, grad_max_in;
   grad_type  grad_min_ff, grad_min_in;
   coord_type peak_x_ff, peak_x_in;
   coord_type peak_y_ff, peak_y_in;
   coord_type prev_x_ff, prev_x_in;
   coord_type prev_y_ff, prev_y_in;
   count_type count_ff, count_in;

   // result register
   logic      out_valid_ff, out_valid_in;
   coord_type out_x_ff, out_y_ff;
   grad_type  out_strength_ff;
   logic      out_full_ff;

   logic      out_free, s1_adv, req_take;
   grad_type  thr_s, neg_thr, grad_raw, grad;
   grad_type  max_a, min_a, strength;
   logic      go_up, go_dn, fire_lo, fire_hi, fire, room, emit;
   logic [COORD_BITS:0] sum_x, sum_y;
   coord_type mid_x, mid_y;
   count_type count_inc;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign req_take = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.edge_x        = out_x_ff;
   assign rsp_bus.edge_y        = out_y_ff;
   assign rsp_bus.edge_strength = out_strength_ff;
   assign rsp_bus.budget_full   = out_full_ff;

   // gradient and hysteresis
   always_comb begin
      thr_s    = grad_type'({2'b00, threshold_ff});
      neg_thr  = -thr_s;
      grad_raw = grad_type'({2'b00, s1_luma_ff}) - grad_type'({2'b00, last_luma_ff});
      grad     = (was_green_ff && !s1_green_ff) ? thr_s + grad_type'(1) : grad_raw;
      go_up    = grad > grad_max_ff;
      fire_lo  = go_up && (grad_min_ff < neg_thr);
      max_a    = go_up ? grad : grad_max_ff;
      min_a    = go_up ? thr_s : grad_min_ff;
      go_dn    = grad < min_a;
      fire_hi  = go_dn && (max_a > thr_s);
      fire     = fire_lo || fire_hi;
      room     = count_ff < max_edges_ff;
      emit     = s1_adv && !s1_start_ff && !stopped_ff && fire && room;
      strength = fire_lo ? grad_min_ff : grad_max_ff;
      count_inc = count_ff + count_type'(1);
      sum_x    = {1'b0, prev_x_ff} + {1'b0, s1_x_ff};
      sum_y    = {1'b0, prev_y_ff} + {1'b0, s1_y_ff};
      mid_x    = sum_x[COORD_BITS:1];
      mid_y    = sum_y[COORD_BITS:1];
   end

   // next state
   always_comb begin
      threshold_in = threshold_ff;
      max_edges_in = max_edges_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_EDGE_THRESHOLD: threshold_in = csr_bus.data[LUMA_BITS-1:0];
            CSR_MAX_EDGES:      max_edges_in = csr_bus.data[COUNT_BITS-1:0];
            default: ;
         endcase
      end

      s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
      out_valid_in = s1_adv ? emit : (out_valid_ff && !rsp_bus.ready);

      stopped_in   = stopped_ff;
      last_luma_in = last_luma_ff;
      was_green_in = was_green_ff;
      grad_max_in  = grad_max_ff;
      grad_min_in  = grad_min_ff;
      peak_x_in    = peak_x_ff;
      peak_y_in    = peak_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      count_in     = count_ff;

      if (s1_adv) begin
         if (s1_start_ff) begin
            stopped_in   = 1'b0;
            last_luma_in = s1_luma_ff;
            was_green_in = s1_green_ff;
            grad_max_in  = neg_thr;
            grad_min_in  = thr_s;
            peak_x_in    = s1_x_ff;
            peak_y_in    = s1_y_ff;
            prev_x_in    = s1_x_ff;
            prev_y_in    = s1_y_ff;
            count_in     = '0;
         end else if (!stopped_ff) begin
            if (fire && !room) begin
               stopped_in = 1'b1;
            end else begin
               last_luma_in = s1_luma_ff;
               was_green_in = s1_green_ff;
               grad_max_in  = go_dn ? neg_thr : max_a;
               grad_min_in  = go_dn ? grad : min_a;
               if (go_up || go_dn) begin
                  peak_x_in = mid_x;
                  peak_y_in = mid_y;
               end
               prev_x_in = s1_x_ff;
               prev_y_in = s1_y_ff;
               if (fire) begin
                  count_in = count_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= LUMA_BITS'(16);
         max_edges_ff <= COUNT_BITS'(63);
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         stopped_ff   <= 1'b1;
      end else begin
         threshold_ff <= threshold_in;
         max_edges_ff <= max_edges_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         stopped_ff   <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_luma_ff  <= req_bus.luma;
         s1_green_ff <= req_bus.is_field_green;
         s1_x_ff     <= req_bus.pos_x;
         s1_y_ff     <= req_bus.pos_y;
         s1_start_ff <= req_bus.line_start;
      end
      if (emit) begin
         out_x_ff        <= peak_x_ff;
         out_y_ff        <= peak_y_ff;
         out_strength_ff <= strength;
         out_full_ff     <= (count_inc == max_edges_ff);
      end
      last_luma_ff <= last_luma_in;
      was_green_ff <= was_green_in;
      grad_max_ff  <= grad_max_in;
      grad_min_ff  <= grad_min_in;
      peak_x_ff    <= peak_x_in;
      peak_y_ff    <= peak_y_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      count_ff     <= count_in;
   end

endmodule

`default_nettype wire
